[rtl/assert_macros.svh]
// Assertion macros used by the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted (active low).
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked property that is also checked through reset.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/socks5h_pkg.sv]
// Package for the SOCKS5 client handshake: codes, register indexes and
// the handshake state record. No dependencies.
package socks5h_pkg;

    localparam int TDATA_W = 16;
    localparam int CFG_W   = 24;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_METHOD,
        PH_AUTH,
        PH_CONN,
        PH_ALEN,
        PH_ADDR,
        PH_PORT
    } phase_t;

    // input actions
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_BYTE  = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;
    localparam logic [1:0] ACT_CLOSE = 2'd3;

    // transmit orders
    localparam logic [1:0] SEND_NONE     = 2'd0;
    localparam logic [1:0] SEND_GREETING = 2'd1;
    localparam logic [1:0] SEND_CREDS    = 2'd2;
    localparam logic [1:0] SEND_CONNECT  = 2'd3;

    // status codes
    localparam logic [3:0] ST_BUSY        = 4'd0;
    localparam logic [3:0] ST_READY       = 4'd1;
    localparam logic [3:0] ST_TIMEOUT     = 4'd2;
    localparam logic [3:0] ST_CLOSED      = 4'd3;
    localparam logic [3:0] ST_BAD_VERSION = 4'd4;
    localparam logic [3:0] ST_UNAUTH      = 4'd5;
    localparam logic [3:0] ST_AUTH_FAIL   = 4'd6;
    localparam logic [3:0] ST_NO_METHOD   = 4'd7;
    localparam logic [3:0] ST_BAD_CONN_VER = 4'd8;
    localparam logic [3:0] ST_REFUSED     = 4'd9;
    localparam logic [3:0] ST_BAD_ATYP    = 4'd10;

    // protocol bytes
    localparam logic [7:0] SOCKS_VER      = 8'h05;
    localparam logic [7:0] METH_NONE      = 8'h00;
    localparam logic [7:0] METH_USERPASS  = 8'h02;
    localparam logic [7:0] AUTH_VER       = 8'h01;
    localparam logic [7:0] AUTH_OK        = 8'h00;
    localparam logic [7:0] REP_SUCCESS    = 8'h00;
    localparam logic [7:0] ATYP_IPV4      = 8'h01;
    localparam logic [7:0] ATYP_DOMAIN    = 8'h03;
    localparam logic [7:0] ATYP_IPV6      = 8'h04;

    // configuration register indexes
    localparam logic REG_CREDS_EN = 1'b0;
    localparam logic REG_TIMEOUT  = 1'b1;

    localparam logic [23:0] TIMEOUT_RESET = 24'd10000;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  bytes_left;
        logic [7:0]  first_byte;
        logic [7:0]  code_byte;
        logic [23:0] time_left;
    } hs_state_t;

    typedef struct packed {
        logic [7:0] reply_code;
        logic [3:0] status;
        logic [1:0] send_request;
    } hs_result_t;

endpackage

[rtl/socks5_client_handshake.sv]
// An accepted item passes through the input register, then the result
// register. Throughput: one item per cycle, no bubbles while m_tready
// stays high. Every item gives exactly one result.
// Reset (aresetn low, synchronous): handshake idle, counters and held bytes
// cleared, credentials off, timeout_ticks 10000, both stages empty.
// Top level of the SOCKS5 client handshake sequencer; uses socks5h_pkg, socks5h_step.
module socks5_client_handshake (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [socks5h_pkg::TDATA_W-1:0] s_tdata,  // [1:0] action, [9:2] rx_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [1:0] send_request, [5:2] status, [13:6] reply_code
    output logic [socks5h_pkg::TDATA_W-1:0] m_tdata,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_addr,
    input  logic [socks5h_pkg::CFG_W-1:0]   cfg_wdata
);
    import socks5h_pkg::*;

    logic        in_valid_reg;
    logic [1:0]  action_reg;
    logic [7:0]  rx_byte_reg;
    logic        m_valid_reg;
    hs_result_t  result_reg;
    hs_result_t  result_next;
    hs_state_t   state_reg;
    hs_state_t   state_next;
    logic        creds_en_reg;
    logic [23:0] timeout_reg;
    logic        out_free;
    logic        advance;

    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    socks5h_step u_step (
        .cur           (state_reg),
        .creds_en      (creds_en_reg),
        .timeout_ticks (timeout_reg),
        .action        (action_reg),
        .rx_byte       (rx_byte_reg),
        .nxt           (state_next),
        .result        (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            state_reg    <= '{phase: PH_IDLE, default: '0};
            creds_en_reg <= 1'b0;
            timeout_reg  <= TIMEOUT_RESET;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
                state_reg   <= state_next;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                if (cfg_addr == REG_CREDS_EN) begin
                    creds_en_reg <= cfg_wdata[0];
                end else begin
                    timeout_reg <= cfg_wdata;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            action_reg  <= s_tdata[1:0];
            rx_byte_reg <= s_tdata[9:2];
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, result_reg};

endmodule

[rtl/socks5h_step.sv]
// Next-state and result logic for one handshake item.
// Depends on socks5h_pkg.
module socks5h_step (
    input  socks5h_pkg::hs_state_t  cur,
    input  logic                    creds_en,
    input  logic [23:0]             timeout_ticks,
    input  logic [1:0]              action,
    input  logic [7:0]              rx_byte,
    output socks5h_pkg::hs_state_t  nxt,
    output socks5h_pkg::hs_result_t result
);
    import socks5h_pkg::*;

    logic [1:0] send;
    logic [3:0] status;
    logic [2:0] pos;

    // position within the four-byte connect reply
    assign pos = (cur.bytes_left >= 8'd4) ? 3'd0 : 3'(8'd4 - cur.bytes_left);

    always_comb begin
        nxt    = cur;
        send   = SEND_NONE;
        status = ST_BUSY;
        if (action == ACT_START) begin
            send           = SEND_GREETING;
            nxt.phase      = PH_METHOD;
            nxt.bytes_left = 8'd2;
            nxt.first_byte = '0;
            nxt.code_byte  = '0;
            nxt.time_left  = timeout_ticks;
        end else if (cur.phase != PH_IDLE) begin
            priority if (action == ACT_BYTE) begin
                if (cur.time_left == '0) begin
                    status = ST_TIMEOUT;
                end else begin
                    unique case (cur.phase)
                        PH_METHOD: begin
                            if (cur.bytes_left >= 8'd2) begin
                                nxt.first_byte = rx_byte;
                                nxt.bytes_left = 8'd1;
                            end else if (cur.first_byte != SOCKS_VER) begin
                                status = ST_BAD_VERSION;
                            end else if (rx_byte == METH_NONE) begin
                                if (creds_en) begin
                                    status = ST_UNAUTH;
                                end else begin
                                    send           = SEND_CONNECT;
                                    nxt.phase      = PH_CONN;
                                    nxt.bytes_left = 8'd4;
                                end
                            end else if (rx_byte == METH_USERPASS && creds_en) begin
                                send           = SEND_CREDS;
                                nxt.phase      = PH_AUTH;
                                nxt.bytes_left = 8'd2;
                            end else begin
                                status = ST_NO_METHOD;
                            end
                        end
                        PH_AUTH: begin
                            if (cur.bytes_left >= 8'd2) begin
                                nxt.first_byte = rx_byte;
                                nxt.bytes_left = 8'd1;
                            end else if (cur.first_byte != AUTH_VER || rx_byte != AUTH_OK) begin
                                status = ST_AUTH_FAIL;
                            end else begin
                                send           = SEND_CONNECT;
                                nxt.phase      = PH_CONN;
                                nxt.bytes_left = 8'd4;
                            end
                        end
                        PH_CONN: begin
                            if (pos < 3'd3) begin
                                if (pos == 3'd0) begin
                                    nxt.first_byte = rx_byte;
                                end else if (pos == 3'd1) begin
                                    nxt.code_byte = rx_byte;
                                end
                                nxt.bytes_left = {5'd0, 3'd3 - pos};
                            end else if (cur.first_byte != SOCKS_VER) begin
                                status = ST_BAD_CONN_VER;
                            end else if (cur.code_byte != REP_SUCCESS) begin
                                status = ST_REFUSED;
                            end else if (rx_byte == ATYP_IPV4) begin
                                nxt.phase      = PH_ADDR;
                                nxt.bytes_left = 8'd4;
                            end else if (rx_byte == ATYP_IPV6) begin
                                nxt.phase      = PH_ADDR;
                                nxt.bytes_left = 8'd16;
                            end else if (rx_byte == ATYP_DOMAIN) begin
                                nxt.phase      = PH_ALEN;
                                nxt.bytes_left = 8'd1;
                            end else begin
                                status = ST_BAD_ATYP;
                            end
                        end
                        PH_ALEN: begin
                            // empty domain skips straight to the port
                            if (rx_byte == 8'd0) begin
                                nxt.phase      = PH_PORT;
                                nxt.bytes_left = 8'd2;
                            end else begin
                                nxt.phase      = PH_ADDR;
                                nxt.bytes_left = rx_byte;
                            end
                        end
                        PH_ADDR: begin
                            if (cur.bytes_left > 8'd1) begin
                                nxt.bytes_left = cur.bytes_left - 8'd1;
                            end else begin
                                nxt.phase      = PH_PORT;
                                nxt.bytes_left = 8'd2;
                            end
                        end
                        PH_PORT: begin
                            if (cur.bytes_left > 8'd1) begin
                                nxt.bytes_left = cur.bytes_left - 8'd1;
                            end else begin
                                status = ST_READY;
                            end
                        end
                        default: begin
                            status = ST_BUSY;
                        end
                    endcase
                end
            end else if (action == ACT_TICK) begin
                if (cur.time_left <= 24'd1) begin
                    nxt.time_left = '0;
                    status        = ST_TIMEOUT;
                end else begin
                    nxt.time_left = cur.time_left - 24'd1;
                end
            end else begin
                status = ST_CLOSED;
            end
            if (status != ST_BUSY) begin
                nxt.phase      = PH_IDLE;
                nxt.bytes_left = '0;
            end
        end
    end

    assign result.send_request = send;
    assign result.status       = status;
    assign result.reply_code   = (status == ST_REFUSED) ? nxt.code_byte : 8'd0;

endmodule

[rtl/socks5h_checker.sv]
// Port-level checker for the SOCKS5 client handshake, bound to the top level.
// Depends on socks5h_pkg and assert_macros.svh.
`include "assert_macros.svh"

module socks5h_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [socks5h_pkg::TDATA_W-1:0] m_tdata
);
    import socks5h_pkg::*;

    // nothing comes out in the cycle after reset
    `ASSERT_CLK(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

    `ASSERT_CLK_RST(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")

    // the reply code is only carried with a refused connect
    `ASSERT_CLK_RST(a_reply, aclk, aresetn, m_tvalid |-> (m_tdata[13:6] == 8'd0 || m_tdata[5:2] == ST_REFUSED), "reply code without refusal")

    // a transmit order never comes with a final status
    `ASSERT_CLK_RST(a_send_busy, aclk, aresetn, m_tvalid && m_tdata[1:0] != SEND_NONE |-> m_tdata[5:2] == ST_BUSY, "send order with final status")

    `ASSERT_CLK_RST(a_status_range, aclk, aresetn, m_tvalid |-> (m_tdata[5:2] <= ST_BAD_ATYP && m_tdata[15:14] == 2'b00), "bad result encoding")

endmodule

bind socks5_client_handshake socks5h_checker u_socks5h_checker (.*);

[dv/tb_top.sv]
// Self-checking testbench for socks5_client_handshake: queued stimulus, a
// handshake predictor and an in-order result scoreboard.
// Depends on rtl/socks5h_pkg.sv and rtl/socks5_client_handshake.sv.
module tb_top;
    import socks5h_pkg::*;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [TDATA_W-1:0]   s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 cfg_wr_en = 1'b0;
    logic                 cfg_addr  = 1'b0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // shadow registers and handshake state
    logic         cfg_creds_en = 1'b0;
    logic [23:0]  cfg_timeout  = TIMEOUT_RESET;
    phase_t       hs_phase     = PH_IDLE;
    logic [7:0]   left_cnt     = '0;
    logic [7:0]   first_held   = '0;
    logic [7:0]   code_held    = '0;
    logic [23:0]  ticks_left   = '0;

    logic [TDATA_W-1:0] item_fifo[$];
    hs_result_t         predicted_results[$];
    hs_result_t         mon_got;
    hs_result_t         mon_want;

    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           fail_count    = 0;
    int           quiet_cycles  = 0;
    int           queued_items  = 0;
    logic         sess_over     = 1'b0;
    logic [23:0]  sess_ticks    = '0;

    localparam int QUIET_LIMIT = 3000;
    localparam int DRAIN_WAIT  = 4;

    socks5_client_handshake uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    function automatic hs_result_t handshake_step(input logic [1:0] act, input logic [7:0] rx);
        hs_result_t r;
        logic [7:0] pos;
        r = '0;
        if (act == ACT_START) begin
            r.send_request = SEND_GREETING;
            hs_phase   = PH_METHOD;
            left_cnt   = 8'd2;
            first_held = '0;
            code_held  = '0;
            ticks_left = cfg_timeout;
        end else if (hs_phase != PH_IDLE) begin
            case (act)
                ACT_BYTE: begin
                    if (ticks_left == 0) begin
                        r.status = ST_TIMEOUT;
                    end else begin
                        case (hs_phase)
                            PH_METHOD: begin
                                if (left_cnt >= 2) begin
                                    first_held = rx;
                                    left_cnt   = 8'd1;
                                end else if (first_held != SOCKS_VER) begin
                                    r.status = ST_BAD_VERSION;
                                end else if (rx == METH_NONE) begin
                                    if (cfg_creds_en) begin
                                        r.status = ST_UNAUTH;
                                    end else begin
                                        r.send_request = SEND_CONNECT;
                                        hs_phase = PH_CONN;
                                        left_cnt = 8'd4;
                                    end
                                end else if (rx == METH_USERPASS && cfg_creds_en) begin
                                    r.send_request = SEND_CREDS;
                                    hs_phase = PH_AUTH;
                                    left_cnt = 8'd2;
                                end else begin
                                    r.status = ST_NO_METHOD;
                                end
                            end
                            PH_AUTH: begin
                                if (left_cnt >= 2) begin
                                    first_held = rx;
                                    left_cnt   = 8'd1;
                                end else if (first_held != AUTH_VER || rx != AUTH_OK) begin
                                    r.status = ST_AUTH_FAIL;
                                end else begin
                                    r.send_request = SEND_CONNECT;
                                    hs_phase = PH_CONN;
                                    left_cnt = 8'd4;
                                end
                            end
                            PH_CONN: begin
                                pos = (left_cnt >= 4) ? 8'd0 : 8'd4 - left_cnt;
                                if (pos < 3) begin
                                    if (pos == 0)
                                        first_held = rx;
                                    else if (pos == 1)
                                        code_held = rx;
                                    left_cnt = 8'd3 - pos;
                                end else if (first_held != SOCKS_VER) begin
                                    r.status = ST_BAD_CONN_VER;
                                end else if (code_held != REP_SUCCESS) begin
                                    r.status = ST_REFUSED;
                                end else if (rx == ATYP_IPV4) begin
                                    hs_phase = PH_ADDR;
                                    left_cnt = 8'd4;
                                end else if (rx == ATYP_IPV6) begin
                                    hs_phase = PH_ADDR;
                                    left_cnt = 8'd16;
                                end else if (rx == ATYP_DOMAIN) begin
                                    hs_phase = PH_ALEN;
                                    left_cnt = 8'd1;
                                end else begin
                                    r.status = ST_BAD_ATYP;
                                end
                            end
                            PH_ALEN: begin
                                // empty domain skips straight to the port
                                if (rx == 0) begin
                                    hs_phase = PH_PORT;
                                    left_cnt = 8'd2;
                                end else begin
                                    hs_phase = PH_ADDR;
                                    left_cnt = rx;
                                end
                            end
                            PH_ADDR: begin
                                if (left_cnt > 1) begin
                                    left_cnt--;
                                end else begin
                                    hs_phase = PH_PORT;
                                    left_cnt = 8'd2;
                                end
                            end
                            PH_PORT: begin
                                if (left_cnt > 1)
                                    left_cnt--;
                                else
                                    r.status = ST_READY;
                            end
                            default: ;
                        endcase
                    end
                end
                ACT_TICK: begin
                    if (ticks_left <= 1) begin
                        ticks_left = '0;
                        r.status = ST_TIMEOUT;
                    end else begin
                        ticks_left--;
                    end
                end
                default: r.status = ST_CLOSED;
            endcase
            if (r.status != ST_BUSY) begin
                hs_phase = PH_IDLE;
                left_cnt = '0;
            end
        end
        if (r.status == ST_REFUSED)
            r.reply_code = code_held;
        return r;
    endfunction

    task automatic queue_item(input logic [1:0] act, input logic [7:0] b);
        logic [TDATA_W-1:0] word;
        word = {{(TDATA_W-10){1'b0}}, b, act};
        item_fifo.insert(item_fifo.size(), word);
        queued_items++;
    endtask

    // proxy byte within a session, with the odd tick or close mixed in
    task automatic queue_rx(input logic [7:0] b);
        if (sess_over)
            return;
        if ($urandom_range(99) < 2) begin
            queue_item(ACT_CLOSE, 8'($urandom));
            sess_over = 1'b1;
            return;
        end
        if ($urandom_range(99) < 12) begin
            queue_item(ACT_TICK, 8'($urandom));
            if (sess_ticks <= 1) begin
                sess_over = 1'b1;
                return;
            end
            sess_ticks--;
        end
        queue_item(ACT_BYTE, b);
        if (sess_ticks == 0)
            sess_over = 1'b1;
    endtask

    task automatic queue_session();
        logic [7:0] ver, meth, a_ver, a_st, code, atyp;
        int len;
        int pick;
        queue_item(ACT_START, 8'($urandom));
        sess_over  = 1'b0;
        sess_ticks = cfg_timeout;

        ver  = ($urandom_range(99) < 5) ? 8'($urandom) : SOCKS_VER;
        pick = $urandom_range(99);
        if (pick < 80)
            meth = cfg_creds_en ? METH_USERPASS : METH_NONE;
        else if (pick < 90)
            meth = cfg_creds_en ? METH_NONE : METH_USERPASS;
        else
            meth = 8'($urandom);
        queue_rx(ver);
        queue_rx(meth);
        if (ver != SOCKS_VER)
            sess_over = 1'b1;
        if (cfg_creds_en) begin
            if (meth == METH_USERPASS) begin
                a_ver = ($urandom_range(99) < 5) ? 8'($urandom) : AUTH_VER;
                a_st  = ($urandom_range(99) < 5) ? 8'($urandom) : AUTH_OK;
                queue_rx(a_ver);
                queue_rx(a_st);
                if (a_ver != AUTH_VER || a_st != AUTH_OK)
                    sess_over = 1'b1;
            end else begin
                sess_over = 1'b1;
            end
        end else if (meth != METH_NONE) begin
            sess_over = 1'b1;
        end

        ver  = ($urandom_range(99) < 5) ? 8'($urandom) : SOCKS_VER;
        code = ($urandom_range(99) < 6) ? 8'($urandom_range(255, 1)) : REP_SUCCESS;
        pick = $urandom_range(99);
        if (pick < 30)
            atyp = ATYP_IPV4;
        else if (pick < 55)
            atyp = ATYP_IPV6;
        else if (pick < 92)
            atyp = ATYP_DOMAIN;
        else
            atyp = 8'($urandom);
        queue_rx(ver);
        queue_rx(code);
        queue_rx(8'($urandom));
        queue_rx(atyp);
        if (ver != SOCKS_VER || code != REP_SUCCESS)
            sess_over = 1'b1;
        len = 0;
        case (atyp)
            ATYP_IPV4: len = 4;
            ATYP_IPV6: len = 16;
            ATYP_DOMAIN: begin
                len = ($urandom_range(39) == 0) ? $urandom_range(255) : $urandom_range(5);
                queue_rx(8'(len));
            end
            default: sess_over = 1'b1;
        endcase
        repeat (len)
            queue_rx(8'($urandom));
        queue_rx(8'($urandom));
        queue_rx(8'($urandom));
    endtask

    // sender holds off until every outstanding result is back
    task automatic wait_drain();
        while (item_fifo.size() != 0 || s_tvalid || predicted_results.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_config(input logic auth, input logic [23:0] tmo);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_CREDS_EN;
        cfg_wdata <= {{(CFG_W-1){1'b0}}, auth};
        @(posedge aclk);
        cfg_addr  <= REG_TIMEOUT;
        cfg_wdata <= tmo;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_creds_en = auth;
        cfg_timeout  = tmo;
        @(negedge aclk);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                predicted_results.insert(predicted_results.size(),
                                         handshake_step(s_tdata[1:0], s_tdata[9:2]));
            if (!s_tvalid || s_tready) begin
                if (item_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= item_fifo.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and scoreboard
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                mon_got = hs_result_t'(m_tdata[13:0]);
                if (predicted_results.size() == 0) begin
                    $error("result with no item outstanding: 0x%h", m_tdata);
                    fail_count++;
                end else begin
                    mon_want = predicted_results.pop_front();
                    if (mon_got.send_request != mon_want.send_request) begin
                        $error("send_request: expected %0d, got %0d",
                               mon_want.send_request, mon_got.send_request);
                        fail_count++;
                    end
                    if (mon_got.status != mon_want.status) begin
                        $error("status: expected %0d, got %0d",
                               mon_want.status, mon_got.status);
                        fail_count++;
                    end
                    if (mon_got.reply_code != mon_want.reply_code) begin
                        $error("reply_code: expected %0d, got %0d",
                               mon_want.reply_code, mon_got.reply_code);
                        fail_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        int ph;
        logic        auth;
        logic [23:0] tmo;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        send_idle_pct = 8;
        recv_idle_pct = 84;

        // reset config: no auth, 10000 ticks
        queue_item(ACT_BYTE, 8'hFF);            // ignored while idle
        queue_item(ACT_TICK, 8'h00);
        queue_item(ACT_CLOSE, 8'hA5);
        queue_item(ACT_START, 8'h00);
        queue_item(ACT_START, 8'hFF);           // restart
        queue_item(ACT_BYTE, SOCKS_VER);
        queue_item(ACT_BYTE, METH_USERPASS);    // not offered
        queue_item(ACT_START, 8'h00);
        queue_item(ACT_BYTE, 8'h04);
        queue_item(ACT_BYTE, METH_NONE);        // bad version
        queue_item(ACT_START, 8'h00);
        queue_item(ACT_BYTE, SOCKS_VER);
        queue_item(ACT_BYTE, METH_NONE);
        queue_item(ACT_CLOSE, 8'h00);
        queue_item(ACT_START, 8'h00);
        queue_item(ACT_BYTE, SOCKS_VER);
        queue_item(ACT_BYTE, METH_NONE);
        queue_item(ACT_BYTE, SOCKS_VER);
        queue_item(ACT_BYTE, REP_SUCCESS);
        queue_item(ACT_BYTE, 8'hAB);
        queue_item(ACT_BYTE, ATYP_DOMAIN);
        queue_item(ACT_BYTE, 8'h00);            // empty domain
        queue_item(ACT_BYTE, 8'h12);
        queue_item(ACT_BYTE, 8'h34);
        wait_drain();

        queued_items = 0;
        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin auth = 1'b1; tmo = 24'hFFFFFF; end
                1: begin auth = 1'b0; tmo = 24'd0;      end
                2: begin auth = 1'b1; tmo = 24'd6;      end
                3: begin auth = 1'b0; tmo = 24'd1;      end
                4: begin auth = 1'b1; tmo = 24'd40;     end
                default: begin auth = 1'b0; tmo = 24'd12; end
            endcase
            write_config(auth, tmo);
            send_idle_pct = (ph < 2) ? 8 : (ph < 4) ? 84 : 0;
            recv_idle_pct = (ph < 2) ? 84 : (ph < 4) ? 8 : 0;
            while (queued_items < (ph + 1) * 67) begin
                if ($urandom_range(99) < 10) begin
                    repeat ($urandom_range(6, 2))
                        queue_item(2'($urandom), 8'($urandom));
                end else begin
                    queue_session();
                end
            end
            wait_drain();
        end

        if (predicted_results.size() != 0) begin
            $error("%0d results never arrived", predicted_results.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
